/* rtl/core/nlcd_pkg.sv */
// nlcd_pkg: shared widths, divider constants and the seven-segment table
// for the reading-to-LCD row encoder
// no dependencies
package nlcd_pkg;

    localparam int unsigned ReadingW = 16;
    localparam int unsigned RowW     = 18;
    localparam int unsigned SegW     = 7;
    localparam int unsigned DigW     = 4;
    localparam int unsigned SatW     = 14;

    localparam logic [SatW-1:0] SatMax = 14'd9999;

    // reciprocal multipliers: q = (x * K) >> S, exact over each stage's range
    localparam logic [SatW-1:0] RecipThou  = 14'd8389;
    localparam int unsigned     ShiftThou  = 23;
    localparam logic [5:0]      RecipHund  = 6'd41;
    localparam int unsigned     ShiftHund  = 12;
    localparam logic [7:0]      RecipTen   = 8'd205;
    localparam int unsigned     ShiftTen   = 11;

    localparam logic [SegW-1:0] SegBlank = 7'h00;

    typedef logic [DigW-1:0] t_digit;
    typedef logic [SegW-1:0] t_seg;
    typedef logic [RowW-1:0] t_row;

    // segments a..g in bits 0..6
    function automatic t_seg f_seg(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SegBlank;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/nlcd_in_if.sv */
// nlcd_in_if: valid/ready channel carrying one reading per beat
// depends on nlcd_pkg
interface nlcd_in_if;
    logic                            valid;
    logic                            ready;
    logic [nlcd_pkg::ReadingW-1:0]   reading;

    modport source (output valid, output reading, input ready);
    modport sink   (input valid, input reading, output ready);
endinterface

/* rtl/core/nlcd_out_if.sv */
// nlcd_out_if: valid/ready channel carrying the four row words per beat
// depends on nlcd_pkg
interface nlcd_out_if;
    logic                        valid;
    logic                        ready;
    logic [nlcd_pkg::RowW-1:0]   row0_word;
    logic [nlcd_pkg::RowW-1:0]   row1_word;
    logic [nlcd_pkg::RowW-1:0]   row2_word;
    logic [nlcd_pkg::RowW-1:0]   row3_word;

    modport source (output valid, output row0_word, output row1_word,
                    output row2_word, output row3_word, input ready);
    modport sink   (input valid, input row0_word, input row1_word,
                    input row2_word, input row3_word, output ready);
endinterface

/* rtl/core/number_to_lcd_segment_rows.sv */
// number_to_lcd_segment_rows: saturating binary-to-decimal split and
// seven-segment row packing for a 4-digit multiplexed LCD
// depends on nlcd_pkg, nlcd_in_if, nlcd_out_if
//
//  channel   dir  payload                               beat
//  i_rd      in   reading[15:0]                         valid & ready
//  o_rows    out  row0_word..row3_word, 18 bits each    valid & ready
//
//  four register stages: thousands, hundreds, tens/units, row packing
//  one beat per cycle sustained while o_rows.ready is held high
//  each stage has its own valid bit and loads when empty or moving on,
//  so bubbles close up under a stall and nothing is lost or repeated
//  synchronous active-low reset clears the valid bits only
module number_to_lcd_segment_rows (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nlcd_in_if.sink    i_rd,
    nlcd_out_if.source o_rows
);
    import nlcd_pkg::*;

    logic [3:0] r_vld;
    logic [3:0] adv;

    // stage 1
    t_digit     r_d0_s1;
    logic [9:0] r_rem_s1;
    // stage 2
    t_digit     r_d0_s2, r_d1_s2;
    logic [6:0] r_rem_s2;
    // stage 3
    t_digit     r_d0_s3, r_d1_s3, r_d2_s3, r_d3_s3;
    // stage 4
    t_row       r_row0, r_row1, r_row2, r_row3;

    logic [SatW-1:0]   sat_v;
    logic [2*SatW-1:0] prod_thou;
    t_digit            q_thou;
    logic [15:0]       prod_hund;
    t_digit            q_hund;
    logic [14:0]       prod_ten;
    t_digit            q_ten;
    t_seg              c0, c1, c2, c3;
    t_row              n_row0, n_row1, n_row2, n_row3;

    assign adv[3] = !r_vld[3] || o_rows.ready;
    assign adv[2] = !r_vld[2] || adv[3];
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];

    assign i_rd.ready = adv[0];

    always_comb begin
        sat_v     = (i_rd.reading > ReadingW'(SatMax)) ? SatMax
                                                       : i_rd.reading[SatW-1:0];
        prod_thou = (2*SatW)'(sat_v) * (2*SatW)'(RecipThou);
        q_thou    = prod_thou[ShiftThou +: DigW];
        prod_hund = 16'(r_rem_s1) * 16'(RecipHund);
        q_hund    = prod_hund[ShiftHund +: DigW];
        prod_ten  = 15'(r_rem_s2) * 15'(RecipTen);
        q_ten     = prod_ten[ShiftTen +: DigW];
    end

    // leading blanks; third digit always shown
    always_comb begin
        c0 = (r_d0_s3 == '0) ? SegBlank : f_seg(r_d0_s3);
        c1 = (r_d0_s3 == '0 && r_d1_s3 == '0) ? SegBlank : f_seg(r_d1_s3);
        c2 = f_seg(r_d2_s3);
        c3 = f_seg(r_d3_s3);

        n_row0 = '0;
        n_row1 = '0;
        n_row2 = '0;
        n_row3 = '0;

        n_row0[4]  = c0[0];  n_row0[11] = c0[1];
        n_row0[12] = c1[0];  n_row0[13] = c1[1];
        n_row0[14] = c2[0];  n_row0[15] = c2[1];
        n_row0[16] = c3[0];  n_row0[17] = c3[1];

        n_row1[4]  = c0[5];  n_row1[11] = c0[6];
        n_row1[12] = c1[5];  n_row1[13] = c1[6];
        n_row1[14] = c2[5];  n_row1[15] = c2[6];
        n_row1[16] = c3[5];  n_row1[17] = c3[6];

        n_row2[4]  = c0[4];  n_row2[11] = c0[2];
        n_row2[12] = c1[4];  n_row2[13] = c1[2];
        n_row2[14] = c2[4];  n_row2[15] = c2[2];
        n_row2[16] = c3[4];  n_row2[17] = c3[2];

        n_row3[11] = c0[3];
        n_row3[13] = c1[3];
        n_row3[15] = c2[3];
        n_row3[17] = c3[3];
        n_row3[16] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_rd.valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d0_s1  <= q_thou;
            r_rem_s1 <= 10'(sat_v - SatW'(q_thou) * 14'd1000);
        end
        if (adv[1]) begin
            r_d0_s2  <= r_d0_s1;
            r_d1_s2  <= q_hund;
            r_rem_s2 <= 7'(r_rem_s1 - 10'(q_hund) * 10'd100);
        end
        if (adv[2]) begin
            r_d0_s3 <= r_d0_s2;
            r_d1_s3 <= r_d1_s2;
            r_d2_s3 <= q_ten;
            r_d3_s3 <= 4'(r_rem_s2 - 7'(q_ten) * 7'd10);
        end
        if (adv[3]) begin
            r_row0 <= n_row0;
            r_row1 <= n_row1;
            r_row2 <= n_row2;
            r_row3 <= n_row3;
        end
    end

    assign o_rows.valid     = r_vld[3];
    assign o_rows.row0_word = r_row0;
    assign o_rows.row1_word = r_row1;
    assign o_rows.row2_word = r_row2;
    assign o_rows.row3_word = r_row3;

`ifndef SYNTHESIS
    a_dot_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rows.valid |-> o_rows.row3_word[16])
        else $error("decimal dot not lit");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rd.ready |-> (r_vld == 4'b1111))
        else $error("input stalled with a free stage");

    a_third_digit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rows.valid |-> ((o_rows.row0_word[15:14] != 2'b00)
                          || (o_rows.row1_word[15:14] != 2'b00)
                          || (o_rows.row2_word[15:14] != 2'b00)
                          || o_rows.row3_word[15]))
        else $error("third digit blank");

    a_units_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_d3_s3 <= 4'd9 && r_d2_s3 <= 4'd9 && r_d1_s3 <= 4'd9))
        else $error("decimal digit out of range");
`endif

endmodule
